// ----- design/ipt_pkg.sv -----
`timescale 1ns / 1ps
package ipt_pkg;
	localparam int TableEntries = 256;
	localparam int HashBuckets = 64;
	localparam int IdxW = $clog2(TableEntries);
	localparam int CntW = IdxW + 1;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_REMOVE_EXACT = 3'd2;
	localparam logic [2:0] CMD_LOOKUP = 3'd3;
	localparam logic [2:0] CMD_COUNT = 3'd4;

	localparam logic [3:0] ST_ADDED = 4'd0;
	localparam logic [3:0] ST_UPDATED = 4'd1;
	localparam logic [3:0] ST_IGNORED = 4'd2;
	localparam logic [3:0] ST_FULL = 4'd3;
	localparam logic [3:0] ST_REMOVED = 4'd4;
	localparam logic [3:0] ST_DECREMENTED = 4'd5;
	localparam logic [3:0] ST_NOT_FOUND = 4'd6;
	localparam logic [3:0] ST_KERNEL_GUARD = 4'd7;
	localparam logic [3:0] ST_LOOKED_UP = 4'd8;
	localparam logic [3:0] ST_COUNTED = 4'd9;

	localparam logic [31:0] KERNEL_BASE_RST = 32'h8000_0000;
	localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
	localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;
	localparam logic [31:0] PAGE_MASK = 32'h0000_0FFF;
	localparam logic [23:0] SUM_MAX = 24'hFF_FFFF;
	localparam logic [15:0] REFS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [47:0] key;
		logic [19:0] frame;
		logic [11:0] flag_bits;
		logic [15:0] refs;
	} entry_t;

	typedef struct packed {
		logic [3:0] status;
		logic entry_found;
		logic [19:0] found_frame;
		logic [11:0] found_flags;
		logic [15:0] found_refs;
		logic [23:0] remaining_refs;
	} result_t;

	typedef struct packed {
		logic start;
		logic [31:0] x;
	} hash_req_t;
endpackage

// ----- design/inverted_page_table_engine.sv -----
`timescale 1ns / 1ps
// Reference-counted inverted page table. Each beat on s_axis carries one command and
// produces one result beat on m_axis. Entries sit in a synchronous RAM of 256 rows with one
// read and one write port; the valid bit of each row is kept in flip-flops and cleared by
// reset. Keys and frame totals are found by sweeping every row, one read per cycle, so the
// sweep over the read port sets the rate. An ignored command goes straight to its result;
// lookup and a remove that misses take a find sweep, an add takes a find sweep and, when
// the key is new, a probe of occupied rows from the hashed start slot, count_frame and the
// kernel guard take a frame total sweep, and a remove that hits takes a find sweep and then
// a frame total sweep. The next beat is taken once the result beat has left.
module inverted_page_table_engine (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [31:0] cfg_wr_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// [2:0] command, [18:3] pid, [50:19] va_address, [82:51] pa_address,
	// [94:83] flags, [114:95] frame_number, rest zero
	input logic [119:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [3:0] status, [4] entry_found, [24:5] found_frame, [36:25] found_flags,
	// [52:37] found_refs, [76:53] remaining_refs, rest zero
	output logic [79:0] m_axis_tdata
);
	localparam int IdxW = ipt_pkg::IdxW;
	localparam int CntW = ipt_pkg::CntW;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIND = 3'd1;
	localparam logic [2:0] S_MOD = 3'd2;
	localparam logic [2:0] S_SUM = 3'd3;
	localparam logic [2:0] S_FREE = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [31:0] kernel_base_q;
	logic [2:0] state_q;
	logic [2:0] cmd_q;
	logic [47:0] key_q;
	logic [19:0] frame_q;
	logic [19:0] new_frame_q;
	logic [11:0] flags_q;
	logic [CntW-1:0] cnt_q;
	logic rd_pend_s1;
	logic [IdxW-1:0] rd_idx_s1;
	logic hit_q;
	logic [IdxW-1:0] hit_idx_q;
	ipt_pkg::entry_t hit_ent_q;
	logic [23:0] sum_q;
	logic [IdxW-1:0] free_idx_q;
	logic [IdxW-1:0] start_slot_q;
	logic hash_ok_q;
	ipt_pkg::result_t res_q;
	logic out_valid_q;
	logic [ipt_pkg::TableEntries-1:0] valid_q;
	ipt_pkg::entry_t mem [ipt_pkg::TableEntries];
	ipt_pkg::entry_t rd_data_s1;
	logic wr_en;
	logic [IdxW-1:0] wr_idx;
	ipt_pkg::entry_t wr_data;
	logic [IdxW-1:0] rd_idx;
	ipt_pkg::hash_req_t hreq;
	logic hash_done;
	logic [IdxW-1:0] hash_slot;
	logic [2:0] in_cmd;
	logic [15:0] in_pid;
	logic [31:0] in_va;
	logic [31:0] in_pa;
	logic [11:0] in_flags;
	logic [19:0] in_fn;
	logic [31:0] av;
	logic take;
	logic [24:0] sum_next;
	ipt_pkg::result_t in_res;
	logic [2:0] in_next;
	logic [47:0] in_key;
	logic [19:0] in_frame;

	assign in_cmd = s_axis_tdata[2:0];
	assign in_pid = s_axis_tdata[18:3];
	assign in_va = s_axis_tdata[50:19];
	assign in_pa = s_axis_tdata[82:51];
	assign in_flags = s_axis_tdata[94:83];
	assign in_fn = s_axis_tdata[114:95];
	assign av = in_va & ~ipt_pkg::PAGE_MASK;

	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
	assign take = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'd0, res_q.remaining_refs, res_q.found_refs, res_q.found_flags,
		res_q.found_frame, res_q.entry_found, res_q.status};

	assign hreq.start = take && (in_cmd == ipt_pkg::CMD_ADD);
	assign hreq.x = {16'd0, in_pid} ^ in_va;
	slot_hash u_hash (.clk(clk), .arst_n(arst_n), .req(hreq), .done(hash_done),
		.slot(hash_slot));

	// Hold the start slot of the free search once the hash settles
	always_ff @(posedge clk) begin
		if (hash_done) begin
			start_slot_q <= hash_slot;
		end
	end

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_base_q <= ipt_pkg::KERNEL_BASE_RST;
		end else if (cfg_wr_en) begin
			kernel_base_q <= cfg_wr_data;
		end
	end

	// Entry RAM, one read and one write port, registered read
	assign rd_idx = cnt_q[IdxW-1:0];
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rd_data_s1 <= mem[rd_idx];
	end

	// Saturating accumulate of the frame total
	always_comb begin
		sum_next = {1'b0, sum_q} + 25'(rd_data_s1.refs);
		if (sum_next > {1'b0, ipt_pkg::SUM_MAX}) begin
			sum_next = {1'b0, ipt_pkg::SUM_MAX};
		end
	end

	// Decode the incoming command into its key, frame and first step
	always_comb begin
		in_res = '0;
		in_res.status = ipt_pkg::ST_IGNORED;
		in_next = S_FIND;
		in_key = {in_pid, in_va};
		in_frame = in_fn;
		unique case (in_cmd) inside
			ipt_pkg::CMD_ADD: begin
				if (!in_flags[2] || in_pa == 32'd0) begin
					in_next = S_DONE;
				end
			end
			ipt_pkg::CMD_REMOVE: begin
				in_key = {in_pid, av};
				in_frame = in_pa[31:12];
				if (av >= kernel_base_q) begin
					in_res.status = ipt_pkg::ST_KERNEL_GUARD;
					in_next = S_SUM;
				end
			end
			ipt_pkg::CMD_REMOVE_EXACT, ipt_pkg::CMD_LOOKUP: ;
			ipt_pkg::CMD_COUNT: begin
				in_res.status = ipt_pkg::ST_COUNTED;
				in_next = S_SUM;
			end
			default: in_next = S_DONE;
		endcase
	end

	// Write-back decode for the modify step
	always_comb begin
		wr_en = 1'b0;
		wr_idx = hit_idx_q;
		wr_data = hit_ent_q;
		if (state_q == S_MOD) begin
			if (cmd_q == ipt_pkg::CMD_ADD) begin
				wr_en = hit_q || hash_ok_q;
				wr_idx = hit_q ? hit_idx_q : free_idx_q;
				wr_data.key = key_q;
				wr_data.frame = new_frame_q;
				wr_data.flag_bits = flags_q;
				wr_data.refs = hit_q ? ((hit_ent_q.refs == ipt_pkg::REFS_MAX) ?
					hit_ent_q.refs : hit_ent_q.refs + 16'd1) : 16'd1;
			end else if (hit_q && hit_ent_q.refs > 16'd1 &&
					(cmd_q == ipt_pkg::CMD_REMOVE ||
					(cmd_q == ipt_pkg::CMD_REMOVE_EXACT && hit_ent_q.frame == frame_q))) begin
				wr_en = 1'b1;
				wr_data.refs = hit_ent_q.refs - 16'd1;
			end
		end
	end

	// Sequence sweeps over the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			valid_q <= '0;
			rd_pend_s1 <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (state_q == S_DONE) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						cmd_q <= in_cmd;
						flags_q <= in_flags;
						new_frame_q <= in_pa[31:12];
						key_q <= in_key;
						frame_q <= in_frame;
						res_q <= in_res;
						hit_q <= 1'b0;
						sum_q <= '0;
						hash_ok_q <= 1'b0;
						cnt_q <= '0;
						rd_pend_s1 <= 1'b0;
						state_q <= in_next;
					end
				end
				S_FIND: begin
					rd_pend_s1 <= !cnt_q[IdxW];
					rd_idx_s1 <= rd_idx;
					if (rd_pend_s1 && !hit_q && valid_q[rd_idx_s1] &&
							rd_data_s1.key == key_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= rd_idx_s1;
						hit_ent_q <= rd_data_s1;
					end
					if (!cnt_q[IdxW]) begin
						cnt_q <= cnt_q + CntW'(1);
					end else if (!rd_pend_s1) begin
						cnt_q <= '0;
						free_idx_q <= start_slot_q;
						state_q <= (cmd_q == ipt_pkg::CMD_ADD) ? S_FREE : S_MOD;
					end
				end
				S_FREE: begin
					// probe valid bits from the start slot, with wrap
					if (hit_q || cnt_q[IdxW]) begin
						state_q <= S_MOD;
					end else if (!valid_q[free_idx_q]) begin
						hash_ok_q <= 1'b1;
						state_q <= S_MOD;
					end else begin
						free_idx_q <= free_idx_q + IdxW'(1);
						cnt_q <= cnt_q + CntW'(1);
					end
				end
				S_MOD: begin
					if (cmd_q == ipt_pkg::CMD_ADD) begin
						res_q.entry_found <= hit_q;
						state_q <= S_DONE;
						if (hit_q) begin
							res_q.status <= ipt_pkg::ST_UPDATED;
						end else if (hash_ok_q) begin
							res_q.status <= ipt_pkg::ST_ADDED;
							valid_q[free_idx_q] <= 1'b1;
						end else begin
							res_q.status <= ipt_pkg::ST_FULL;
						end
					end else if (cmd_q == ipt_pkg::CMD_LOOKUP) begin
						res_q.entry_found <= hit_q;
						res_q.status <= ipt_pkg::ST_LOOKED_UP;
						state_q <= S_DONE;
						if (hit_q) begin
							res_q.found_frame <= hit_ent_q.frame;
							res_q.found_flags <= hit_ent_q.flag_bits;
							res_q.found_refs <= hit_ent_q.refs;
						end
					end else if (!hit_q || (cmd_q == ipt_pkg::CMD_REMOVE_EXACT &&
							hit_ent_q.frame != frame_q)) begin
						res_q.status <= ipt_pkg::ST_NOT_FOUND;
						res_q.entry_found <= 1'b0;
						state_q <= S_DONE;
					end else begin
						res_q.entry_found <= 1'b1;
						if (hit_ent_q.refs > 16'd1) begin
							res_q.status <= ipt_pkg::ST_DECREMENTED;
						end else begin
							res_q.status <= ipt_pkg::ST_REMOVED;
							valid_q[hit_idx_q] <= 1'b0;
						end
						cnt_q <= '0;
						rd_pend_s1 <= 1'b0;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					rd_pend_s1 <= !cnt_q[IdxW];
					rd_idx_s1 <= rd_idx;
					if (rd_pend_s1 && valid_q[rd_idx_s1] && rd_data_s1.frame == frame_q) begin
						sum_q <= sum_next[23:0];
					end
					if (!cnt_q[IdxW]) begin
						cnt_q <= cnt_q + CntW'(1);
					end else if (!rd_pend_s1) begin
						res_q.remaining_refs <= (res_q.status == ipt_pkg::ST_KERNEL_GUARD &&
							sum_q == 24'd0) ? 24'd1 : sum_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// A result beat only appears after the done step
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE) else $error("result without done");
	// No input is taken while a result is pending
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !s_axis_tready) else $error("ready while result held");
	// RAM writes occur only in the modify step
	a_wr_mod: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == S_MOD) else $error("stray write");
`endif
endmodule

// ----- design/ipt_hash.sv -----
`timescale 1ns / 1ps
// Multi-cycle mixing hash; one multiply per cycle, result reduced to a bucket slot
module slot_hash (
	input logic clk,
	input logic arst_n,
	input ipt_pkg::hash_req_t req,
	output logic done,
	output logic [ipt_pkg::IdxW-1:0] slot
);
	localparam int IdxW = ipt_pkg::IdxW;

	logic [2:0] step_q;
	logic [31:0] x_q;
	logic [31:0] prod;
	logic [31:0] bucket;

	always_comb begin
		prod = x_q * ((step_q == 3'd1) ? ipt_pkg::HASH_MUL_A : ipt_pkg::HASH_MUL_B);
		bucket = (x_q ^ (x_q >> 16)) % ipt_pkg::HashBuckets;
	end

	// Advance one mixing round a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
		end else if (req.start) begin
			step_q <= 3'd1;
		end else if (step_q != 3'd0 && step_q != 3'd4) begin
			step_q <= step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= req.x ^ (req.x >> 16);
		end else if (step_q == 3'd1) begin
			x_q <= prod ^ (prod >> 15);
		end else if (step_q == 3'd2) begin
			x_q <= prod;
		end
	end

	assign done = (step_q == 3'd3);
	assign slot = IdxW'(bucket % ipt_pkg::TableEntries);
endmodule

// ----- bench/inverted_page_table_engine_tb.sv -----
`timescale 1ns / 1ps
module inverted_page_table_engine_tb;
	localparam logic [2:0] CMD_RSVD_A = 3'd5;
	localparam logic [2:0] CMD_RSVD_B = 3'd6;
	localparam logic [2:0] CMD_RSVD_C = 3'd7;
	localparam logic [11:0] USER_FLAG = 12'h004;
	localparam int SETTLE_CYCLES = 600;

	typedef struct {
		logic [2:0] cmd;
		logic [15:0] pid;
		logic [31:0] va;
		logic [31:0] pa;
		logic [11:0] flags;
		logic [19:0] fn;
	} page_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;

	inverted_page_table_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow table and register
	logic [31:0] kbase = ipt_pkg::KERNEL_BASE_RST;
	bit slot_used [ipt_pkg::TableEntries];
	logic [47:0] slot_key [ipt_pkg::TableEntries];
	logic [19:0] slot_frame [ipt_pkg::TableEntries];
	logic [11:0] slot_flags [ipt_pkg::TableEntries];
	logic [15:0] slot_refs [ipt_pkg::TableEntries];

	page_cmd_t pending_cmds [$];
	ipt_pkg::result_t expected_results [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	bit in_took = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("FAIL inverted_page_table_engine");
		$finish;
	end

	function automatic int find_slot(logic [47:0] k);
		for (int i = 0; i < ipt_pkg::TableEntries; i++)
			if (slot_used[i] && slot_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic logic [23:0] frame_refs_total(logic [19:0] f);
		logic [24:0] sum;
		sum = '0;
		for (int i = 0; i < ipt_pkg::TableEntries; i++)
			if (slot_used[i] && slot_frame[i] == f) begin
				sum = sum + 25'(slot_refs[i]);
				if (sum > {1'b0, ipt_pkg::SUM_MAX})
					sum = {1'b0, ipt_pkg::SUM_MAX};
			end
		return sum[23:0];
	endfunction

	// Release one reference of slot i, freeing it on the last one
	function automatic logic [3:0] drop_ref(int i);
		if (slot_refs[i] > 16'd1) begin
			slot_refs[i] = slot_refs[i] - 16'd1;
			return ipt_pkg::ST_DECREMENTED;
		end
		slot_used[i] = 1'b0;
		return ipt_pkg::ST_REMOVED;
	endfunction

	function automatic ipt_pkg::result_t apply_page_cmd(page_cmd_t c);
		ipt_pkg::result_t r;
		int i;
		logic [31:0] av;
		r = '0;
		r.status = ipt_pkg::ST_IGNORED;
		case (c.cmd)
			ipt_pkg::CMD_ADD: begin
				if ((c.flags & USER_FLAG) != '0 && c.pa != '0) begin
					i = find_slot({c.pid, c.va});
					if (i >= 0) begin
						r.entry_found = 1'b1;
						if (slot_refs[i] != ipt_pkg::REFS_MAX)
							slot_refs[i] = slot_refs[i] + 16'd1;
						slot_frame[i] = c.pa[31:12];
						slot_flags[i] = c.flags;
						r.status = ipt_pkg::ST_UPDATED;
					end else begin
						i = -1;
						for (int j = 0; j < ipt_pkg::TableEntries; j++)
							if (i < 0 && !slot_used[j])
								i = j;
						if (i < 0) begin
							r.status = ipt_pkg::ST_FULL;
						end else begin
							slot_used[i] = 1'b1;
							slot_key[i] = {c.pid, c.va};
							slot_frame[i] = c.pa[31:12];
							slot_flags[i] = c.flags;
							slot_refs[i] = 16'd1;
							r.status = ipt_pkg::ST_ADDED;
						end
					end
				end
			end
			ipt_pkg::CMD_REMOVE: begin
				av = c.va & ~ipt_pkg::PAGE_MASK;
				if (av >= kbase) begin
					r.status = ipt_pkg::ST_KERNEL_GUARD;
					r.remaining_refs = frame_refs_total(c.pa[31:12]);
					if (r.remaining_refs == '0)
						r.remaining_refs = 24'd1;
				end else begin
					i = find_slot({c.pid, av});
					if (i < 0) begin
						r.status = ipt_pkg::ST_NOT_FOUND;
					end else begin
						r.entry_found = 1'b1;
						r.status = drop_ref(i);
						r.remaining_refs = frame_refs_total(c.pa[31:12]);
					end
				end
			end
			ipt_pkg::CMD_REMOVE_EXACT: begin
				i = find_slot({c.pid, c.va});
				if (i < 0 || slot_frame[i] != c.fn) begin
					r.status = ipt_pkg::ST_NOT_FOUND;
				end else begin
					r.entry_found = 1'b1;
					r.status = drop_ref(i);
					r.remaining_refs = frame_refs_total(c.fn);
				end
			end
			ipt_pkg::CMD_LOOKUP: begin
				r.status = ipt_pkg::ST_LOOKED_UP;
				i = find_slot({c.pid, c.va});
				if (i >= 0) begin
					r.entry_found = 1'b1;
					r.found_frame = slot_frame[i];
					r.found_flags = slot_flags[i];
					r.found_refs = slot_refs[i];
				end
			end
			ipt_pkg::CMD_COUNT: begin
				r.status = ipt_pkg::ST_COUNTED;
				r.remaining_refs = frame_refs_total(c.fn);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// Record accepted commands and check result beats
	always @(posedge clk) begin
		ipt_pkg::result_t want;
		ipt_pkg::result_t got;
		in_took <= s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			beats_out++;
			got = '0;
			got.status = m_axis_tdata[3:0];
			got.entry_found = m_axis_tdata[4];
			got.found_frame = m_axis_tdata[24:5];
			got.found_flags = m_axis_tdata[36:25];
			got.found_refs = m_axis_tdata[52:37];
			got.remaining_refs = m_axis_tdata[76:53];
			if (expected_results.size() == 0) begin
				report("unexpected result beat, status", got.status, '0);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status)
					report("status", got.status, want.status);
				if (got.entry_found !== want.entry_found)
					report("entry_found", got.entry_found, want.entry_found);
				if (got.found_frame !== want.found_frame)
					report("found_frame", got.found_frame, want.found_frame);
				if (got.found_flags !== want.found_flags)
					report("found_flags", got.found_flags, want.found_flags);
				if (got.found_refs !== want.found_refs)
					report("found_refs", got.found_refs, want.found_refs);
				if (got.remaining_refs !== want.remaining_refs)
					report("remaining_refs", got.remaining_refs, want.remaining_refs);
				if (m_axis_tdata[79:77] !== '0)
					report("padding", m_axis_tdata[79:77], '0);
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			page_cmd_t c;
			beats_in++;
			c.cmd = s_axis_tdata[2:0];
			c.pid = s_axis_tdata[18:3];
			c.va = s_axis_tdata[50:19];
			c.pa = s_axis_tdata[82:51];
			c.flags = s_axis_tdata[94:83];
			c.fn = s_axis_tdata[114:95];
			expected_results.push_back(apply_page_cmd(c));
		end
	end

	// Feed command beats and throttle the result side
	always @(negedge clk) begin
		page_cmd_t c;
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (!s_axis_tvalid || in_took) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					c = pending_cmds.pop_front();
					s_axis_tdata <= {5'd0, c.fn, c.flags, c.pa, c.va, c.pid, c.cmd};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	function automatic page_cmd_t mk(logic [2:0] cmd, logic [15:0] pid, logic [31:0] va,
			logic [31:0] pa, logic [11:0] flags, logic [19:0] fn);
		page_cmd_t c;
		c.cmd = cmd;
		c.pid = pid;
		c.va = va;
		c.pa = pa;
		c.flags = flags;
		c.fn = fn;
		return c;
	endfunction

	// Mostly well-formed commands over a small key and frame pool, some raw noise
	function automatic page_cmd_t random_cmd();
		logic [15:0] pids [4] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h5A3C};
		logic [31:0] vas [6] = '{32'h0000_1000, 32'h0040_2000, 32'h7FFF_F000,
			32'h8000_0000, 32'hFFFF_F000, 32'h1234_5000};
		logic [19:0] frames [4] = '{20'h00001, 20'hFFFFF, 20'h12345, 20'h00ABC};
		page_cmd_t c;
		int sel;
		c = mk(ipt_pkg::CMD_ADD, pids[$urandom_range(3)], vas[$urandom_range(5)], '0,
			12'($urandom) | USER_FLAG, frames[$urandom_range(3)]);
		c.pa = {frames[$urandom_range(3)], 12'($urandom)};
		sel = $urandom_range(99);
		if (sel < 35) c.cmd = ipt_pkg::CMD_ADD;
		else if (sel < 50) begin
			c.cmd = ipt_pkg::CMD_REMOVE;
			c.va = c.va | 32'($urandom_range(4095));
		end else if (sel < 60) c.cmd = ipt_pkg::CMD_REMOVE_EXACT;
		else if (sel < 72) c.cmd = ipt_pkg::CMD_LOOKUP;
		else if (sel < 78) c.cmd = ipt_pkg::CMD_COUNT;
		else begin
			c = mk(3'($urandom), 16'($urandom), $urandom, $urandom, 12'($urandom),
				20'($urandom));
			if ($urandom_range(1)) c.flags = c.flags & ~USER_FLAG;
		end
		return c;
	endfunction

	task automatic write_kernel_base(logic [31:0] v);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		kbase = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Let the queued commands run out with the given idling, then settle
	task automatic run_phase(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < ipt_pkg::TableEntries; i++)
			slot_used[i] = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed cases at the reset kernel base
		pending_cmds.push_back(mk(ipt_pkg::CMD_ADD, 16'h0001, 32'h0000_3000, 32'h0001_2000,
			12'hFFB, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_ADD, 16'h0001, 32'h0000_3000, 32'h0,
			12'hFFF, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_ADD, 16'h0001, 32'h0000_3000, 32'h0001_2345,
			USER_FLAG, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_ADD, 16'h0001, 32'h0000_3000, 32'hFFFF_FFFF,
			12'hFFF, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_F000,
			12'hFFF, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_LOOKUP, 16'h0001, 32'h0000_3000, '0, '0, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, '0, '0, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_LOOKUP, 16'h0002, 32'h0000_3000, '0, '0, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_COUNT, '0, '0, '0, '0, 20'hFFFFF));
		pending_cmds.push_back(mk(ipt_pkg::CMD_REMOVE, 16'h0001, 32'h0000_3ABC,
			32'hFFFF_F000, '0, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_REMOVE_EXACT, 16'h0001, 32'h0000_3000, '0,
			'0, 20'h00012));
		pending_cmds.push_back(mk(ipt_pkg::CMD_REMOVE_EXACT, 16'h0001, 32'h0000_3000, '0,
			'0, 20'hFFFFF));
		pending_cmds.push_back(mk(ipt_pkg::CMD_REMOVE, 16'h0001, 32'h0000_3000,
			32'hFFFF_F000, '0, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_REMOVE, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_F000, '0, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_REMOVE, 16'h0003, 32'h9000_0000,
			32'h0000_5000, '0, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_REMOVE_EXACT, 16'hFFFF, 32'hFFFF_FFFF, '0,
			'0, 20'hFFFFF));
		pending_cmds.push_back(mk(ipt_pkg::CMD_COUNT, '0, '0, '0, '0, 20'hFFFFF));
		pending_cmds.push_back(mk(CMD_RSVD_A, 16'hFFFF, '1, '1, '1, '1));
		pending_cmds.push_back(mk(CMD_RSVD_B, '0, '0, '0, '0, '0));
		pending_cmds.push_back(mk(CMD_RSVD_C, 16'hFFFF, '1, '1, '1, '1));
		run_phase(0, 0);

		// Fill the table, overflow it, hit while full, then free part of it
		for (int i = 0; i < ipt_pkg::TableEntries; i++)
			pending_cmds.push_back(mk(ipt_pkg::CMD_ADD, 16'h0777, 32'(i) << 12,
				32'((i % 3) + 1) << 12, USER_FLAG, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_ADD, 16'h0778, 32'h0000_1000, 32'h0000_1000,
			USER_FLAG, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_ADD, 16'h0777, 32'h0000_5000, 32'h0000_2000,
			12'h0FF, '0));
		pending_cmds.push_back(mk(ipt_pkg::CMD_COUNT, '0, '0, '0, '0, 20'h00002));
		for (int i = 0; i < 40; i++)
			pending_cmds.push_back(mk(ipt_pkg::CMD_REMOVE, 16'h0777, 32'(i) << 12,
				32'((i % 3) + 1) << 12, '0, '0));
		run_phase(0, 0);

		// Random traffic under several idling patterns and kernel bases
		repeat (20) pending_cmds.push_back(random_cmd());
		run_phase(0, 0);
		write_kernel_base(32'h0000_0000);
		repeat (20) pending_cmds.push_back(random_cmd());
		run_phase(69, 0);
		write_kernel_base(32'hFFFF_FFFF);
		repeat (20) pending_cmds.push_back(random_cmd());
		run_phase(0, 69);
		write_kernel_base($urandom);
		repeat (20) pending_cmds.push_back(random_cmd());
		run_phase(22, 22);
		write_kernel_base(ipt_pkg::KERNEL_BASE_RST);
		repeat (20) pending_cmds.push_back(random_cmd());
		run_phase(0, 0);

		$display("covered %0d command beats and %0d result beats over five kernel bases,",
			beats_in, beats_out);
		$display("including a full table, reserved commands and idle/stall mixes");
		if (errors == 0)
			$display("PASS inverted_page_table_engine");
		else
			$display("FAIL inverted_page_table_engine");
		$finish;
	end
endmodule

// ----- sim.f -----
design/ipt_pkg.sv
design/ipt_hash.sv
design/inverted_page_table_engine.sv
bench/inverted_page_table_engine_tb.sv
